### hw/rtl/mpc_prediction_matrix_builder_top_defines.svh
// Assertion macros used by the prediction matrix builder controller.
`ifndef MPC_PREDICTION_MATRIX_BUILDER_TOP_DEFINES_SVH
`define MPC_PREDICTION_MATRIX_BUILDER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define MPB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MPB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define MPB_ASSERT(lbl, clk, rst_n, prop, msg)
`define MPB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### hw/rtl/mpb_pkg.sv
// Shared types and codes of the prediction matrix builder.
`default_nettype none
package mpb_pkg;
	localparam int DATA_W   = 32;
	localparam int FRAC_W   = 16;
	localparam int MODE_W   = 3;
	localparam int STATUS_W = 2;
	localparam int IN_W     = 48;

	localparam logic [MODE_W-1:0] MODE_WRITE_A = 3'd0;
	localparam logic [MODE_W-1:0] MODE_WRITE_B = 3'd1;
	localparam logic [MODE_W-1:0] MODE_COMPUTE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_READ_S  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_READ_U  = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_INDEX   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_SAT     = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_NOTCOMP = 2'd3;

	localparam logic [1:0] CFG_STATE_SIZE = 2'd0;
	localparam logic [1:0] CFG_INPUT_SIZE = 2'd1;
	localparam logic [1:0] CFG_HORIZON    = 2'd2;

	typedef struct packed {
		logic                load_item;
		logic                exec_write;
		logic                read_issue;
		logic                res_set;
		logic                res_from_ram;
		logic [STATUS_W-1:0] res_code;
		logic                clr_sat;
		logic                copy_start;
		logic                copy_step;
		logic                mac_start;
		logic                mac_issue;
		logic                elem_next;
		logic                set_valid;
		logic                out_load;
	} cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              bad;
		logic              tables_valid;
		logic              sat;
		logic              nh_one;
		logic              cp_last;
		logic              t_last;
		logic              mac_busy;
		logic              elem_last;
		logic              out_free;
	} stat_t;
endpackage
`default_nettype wire

### hw/rtl/mpc_prediction_matrix_builder_top.sv
// Top level of the MPC prediction matrix builder.
//
// One input stream carries a mode in s_tuser and the indices and value in s_tdata; every
// transaction yields exactly one result transaction: result in m_tdata, status in m_tuser.
// Modes: write A, write B, compute tables, read S entry, read U entry.
// The configuration port (cfg_we, cfg_index, cfg_wdata) sets n, m and the horizon; write it
// only while the block is idle. A config write to n, m or the horizon, or an in-range A/B
// write, marks the tables stale.
// The block takes one transaction at a time; a new one is accepted as soon as the previous
// result sits in the output register, even while the receiver holds m_tready low.
// Compute: a copy sweep of A and B into the tables, then for each of the N-1 steps n*(n+m)
// elements, each on the one shared multiply-accumulate unit (read A and the previous table,
// multiply, accumulate, write back).
// Reset: A and B read as zero, tables stale, registers at 1. When the receiver stalls, the
// result holds in the output register and the next transaction waits in the controller.
`default_nettype none
module mpc_prediction_matrix_builder_top #(
	parameter int MAX_STATES  = 8,
	parameter int MAX_INPUTS  = 4,
	parameter int MAX_HORIZON = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [4:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // row, col, step, stage, input_index, value
	input  wire logic [2:0]  s_tuser,  // mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // result
	output logic [1:0]       m_tuser   // status
);
	mpb_pkg::cmd_t  cmd;
	mpb_pkg::stat_t st;

	mpb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.st(st), .cmd(cmd)
	);

	mpb_datapath #(
		.MAX_STATES(MAX_STATES), .MAX_INPUTS(MAX_INPUTS), .MAX_HORIZON(MAX_HORIZON)
	) u_datapath (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cmd(cmd), .st(st)
	);
endmodule
`default_nettype wire

### hw/rtl/mpb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mpb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### hw/rtl/mpb_ctrl.sv
// Sequencing state machine of the prediction matrix builder.
`default_nettype none
`include "mpc_prediction_matrix_builder_top_defines.svh"
module mpb_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire mpb_pkg::stat_t st,
	output mpb_pkg::cmd_t      cmd
);
	localparam logic [2:0] S_IDLE       = 3'd0;
	localparam logic [2:0] S_EXEC       = 3'd1;
	localparam logic [2:0] S_RD_WAIT    = 3'd2;
	localparam logic [2:0] S_COPY       = 3'd3;
	localparam logic [2:0] S_COPY_DRAIN = 3'd4;
	localparam logic [2:0] S_MAC_ISSUE  = 3'd5;
	localparam logic [2:0] S_MAC_DRAIN  = 3'd6;
	localparam logic [2:0] S_FINISH     = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [mpb_pkg::STATUS_W-1:0] sat_code;

	assign s_tready = (state_q == S_IDLE);
	assign sat_code = st.sat ? mpb_pkg::STATUS_SAT : mpb_pkg::STATUS_OK;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				if (st.bad) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = mpb_pkg::STATUS_INDEX;
					state_d      = S_FINISH;
				end else begin
					case (st.mode) inside
						mpb_pkg::MODE_WRITE_A, mpb_pkg::MODE_WRITE_B: begin
							cmd.exec_write = 1'b1;
							cmd.res_set    = 1'b1;
							cmd.res_code   = mpb_pkg::STATUS_OK;
							state_d        = S_FINISH;
						end
						mpb_pkg::MODE_COMPUTE: begin
							cmd.clr_sat    = 1'b1;
							cmd.copy_start = 1'b1;
							state_d        = S_COPY;
						end
						default: begin
							if (!st.tables_valid) begin
								cmd.res_set  = 1'b1;
								cmd.res_code = mpb_pkg::STATUS_NOTCOMP;
								state_d      = S_FINISH;
							end else begin
								cmd.read_issue = 1'b1;
								state_d        = S_RD_WAIT;
							end
						end
					endcase
				end
			end
			S_RD_WAIT: begin
				cmd.res_set      = 1'b1;
				cmd.res_from_ram = 1'b1;
				cmd.res_code     = sat_code;
				state_d          = S_FINISH;
			end
			S_COPY: begin
				cmd.copy_step = 1'b1;
				if (st.cp_last) begin
					state_d = S_COPY_DRAIN;
				end
			end
			S_COPY_DRAIN: begin
				if (st.nh_one) begin
					cmd.set_valid = 1'b1;
					cmd.res_set   = 1'b1;
					cmd.res_code  = sat_code;
					state_d       = S_FINISH;
				end else begin
					cmd.mac_start = 1'b1;
					state_d       = S_MAC_ISSUE;
				end
			end
			S_MAC_ISSUE: begin
				cmd.mac_issue = 1'b1;
				if (st.t_last) begin
					state_d = S_MAC_DRAIN;
				end
			end
			S_MAC_DRAIN: begin
				// wait for the element's sum to be written back
				if (!st.mac_busy) begin
					if (st.elem_last) begin
						cmd.set_valid = 1'b1;
						cmd.res_set   = 1'b1;
						cmd.res_code  = sat_code;
						state_d       = S_FINISH;
					end else begin
						cmd.elem_next = 1'b1;
						state_d       = S_MAC_ISSUE;
					end
				end
			end
			S_FINISH: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`MPB_ASSERT_IMP(a_out_load_free, clk, arst_n, cmd.out_load, st.out_free, "output overwritten")
	`MPB_ASSERT_IMP(a_read_valid, clk, arst_n, cmd.read_issue, st.tables_valid && !st.bad, "read of stale tables")
	`MPB_ASSERT_IMP(a_valid_drained, clk, arst_n, cmd.set_valid, !st.mac_busy, "tables marked valid mid compute")
endmodule
`default_nettype wire

### hw/rtl/mpb_datapath.sv
// Datapath: matrix stores, power and drive tables, multiply-accumulate and output register.
`default_nettype none
module mpb_datapath #(
	parameter int MAX_STATES  = 8,
	parameter int MAX_INPUTS  = 4,
	parameter int MAX_HORIZON = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [1:0]                        cfg_index,
	input  wire logic [4:0]                        cfg_wdata,
	input  wire logic [mpb_pkg::IN_W-1:0]          s_tdata,
	input  wire logic [mpb_pkg::MODE_W-1:0]        s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [mpb_pkg::DATA_W-1:0]             m_tdata,
	output logic [mpb_pkg::STATUS_W-1:0]           m_tuser,
	input  wire mpb_pkg::cmd_t                     cmd,
	output mpb_pkg::stat_t                         st
);
	localparam int DW   = mpb_pkg::DATA_W;
	localparam int FW   = mpb_pkg::FRAC_W;
	localparam int MS   = MAX_STATES;
	localparam int MI   = MAX_INPUTS;
	localparam int MH   = MAX_HORIZON;
	localparam int PS_DEPTH = MS * MS;
	localparam int DS_DEPTH = MS * MI;
	localparam int PT_DEPTH = MH * PS_DEPTH;
	localparam int DT_DEPTH = MH * DS_DEPTH;
	localparam int AAW  = (PS_DEPTH > 1) ? $clog2(PS_DEPTH) : 1;
	localparam int BAW  = (DS_DEPTH > 1) ? $clog2(DS_DEPTH) : 1;
	localparam int PAW  = (PT_DEPTH > 1) ? $clog2(PT_DEPTH) : 1;
	localparam int DAW  = (DT_DEPTH > 1) ? $clog2(DT_DEPTH) : 1;
	localparam int CP_N = (PS_DEPTH > DS_DEPTH) ? PS_DEPTH : DS_DEPTH;
	localparam int CPW  = $clog2(CP_N + 1);
	localparam int NCW  = $clog2(MS + 1);
	localparam int MCW  = $clog2(MI + 1);
	localparam int HCW  = $clog2(MH + 1);
	localparam int SIW  = (MS > 1) ? $clog2(MS) : 1;
	localparam int CMAX = (MS > MI) ? MS : MI;
	localparam int CIW  = (CMAX > 1) ? $clog2(CMAX) : 1;
	localparam int HIW  = (MH > 1) ? $clog2(MH) : 1;
	localparam int TW   = 2 * DW - FW;
	localparam int ACC_W = TW + $clog2(MS) + 1;
	localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-DW+1){1'b1}}, {(DW-1){1'b0}}};

	// configuration registers
	logic [3:0] state_size_q;
	logic [2:0] input_size_q;
	logic [4:0] horizon_q;
	logic [NCW-1:0] n;
	logic [MCW-1:0] m;
	logic [HCW-1:0] nh;

	// current transaction
	logic [mpb_pkg::MODE_W-1:0] mode_q;
	logic [2:0]  row_q, col_q;
	logic [3:0]  step_q, stage_q;
	logic [1:0]  jin_q;
	logic [DW-1:0] value_q;
	logic bad;
	logic u_zero;

	logic tables_valid_q;
	logic sat_q;
	logic [PS_DEPTH-1:0] a_vld_q;
	logic [DS_DEPTH-1:0] b_vld_q;

	// memory ports
	logic a_we, b_we, p_we, d_we;
	logic [AAW-1:0] a_waddr, a_raddr;
	logic [BAW-1:0] b_waddr, b_raddr;
	logic [PAW-1:0] p_waddr, p_raddr;
	logic [DAW-1:0] d_waddr, d_raddr;
	logic [DW-1:0]  a_rdata, b_rdata, p_rdata, d_rdata;
	logic [DW-1:0]  p_wdata, d_wdata;

	// copy sweep
	logic [CPW-1:0] cp_q;
	logic [CPW-1:0] cp_addr_s1;
	logic cpa_v_s1, cpb_v_s1;
	logic a_ok_s1, b_ok_s1;

	// multiply-accumulate loop
	logic [HIW-1:0] d_q;
	logic [SIW-1:0] r_q, t_q;
	logic [CIW-1:0] c_q;
	logic phase_d_q;
	logic v_s1, last_s1, v_s2, last_s2, last_s3;
	logic signed [2*DW-1:0] prod_s2;
	logic signed [TW-1:0] term;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [DW-1:0] a_val, src_val;
	logic [DW-1:0] sat_val;
	logic sat_hit;
	logic [31:0] wl;
	logic [31:0] dm1;
	logic [31:0] u_d;
	logic [AAW-1:0] a_mac_addr;
	logic [PAW-1:0] p_src, p_dst, s_addr;
	logic [DAW-1:0] d_src, d_dst, u_addr;

	// pending result and output register
	logic [DW-1:0] res_q;
	logic [mpb_pkg::STATUS_W-1:0] res_st_q;
	logic [DW-1:0] ram_val;
	logic out_free;

	always_comb begin
		if (state_size_q == '0) n = NCW'(1);
		else if (32'(state_size_q) > 32'(MS)) n = NCW'(MS);
		else n = NCW'(state_size_q);
		if (input_size_q == '0) m = MCW'(1);
		else if (32'(input_size_q) > 32'(MI)) m = MCW'(MI);
		else m = MCW'(input_size_q);
		if (horizon_q == '0) nh = HCW'(1);
		else if (32'(horizon_q) > 32'(MH)) nh = HCW'(MH);
		else nh = HCW'(horizon_q);
	end

	always_comb begin
		case (mode_q)
			mpb_pkg::MODE_WRITE_A: bad = (32'(row_q) >= 32'(n)) || (32'(col_q) >= 32'(n));
			mpb_pkg::MODE_WRITE_B: bad = (32'(row_q) >= 32'(n)) || (32'(col_q) >= 32'(m));
			mpb_pkg::MODE_COMPUTE: bad = 1'b0;
			mpb_pkg::MODE_READ_S:  bad = (32'(step_q) >= 32'(nh)) || (32'(row_q) >= 32'(n))
			                           || (32'(col_q) >= 32'(n));
			mpb_pkg::MODE_READ_U:  bad = (32'(jin_q) >= 32'(m)) || (32'(step_q) >= 32'(nh))
			                           || (32'(stage_q) >= 32'(nh)) || (32'(row_q) >= 32'(n));
			default:               bad = 1'b1;
		endcase
	end

	assign u_zero = (stage_q > step_q);
	assign u_d    = 32'(step_q) - 32'(stage_q);
	assign dm1    = 32'(d_q) - 32'd1;
	assign wl     = phase_d_q ? 32'(m) : 32'(n);

	assign a_waddr    = AAW'(32'(row_q) * MS + 32'(col_q));
	assign b_waddr    = BAW'(32'(row_q) * MI + 32'(col_q));
	assign s_addr     = PAW'((32'(step_q) * MS + 32'(col_q)) * MS + 32'(row_q));
	assign u_addr     = DAW'((u_d * MS + 32'(row_q)) * MI + 32'(jin_q));
	assign a_mac_addr = AAW'(32'(r_q) * MS + 32'(t_q));
	assign p_src      = PAW'((dm1 * MS + 32'(t_q)) * MS + 32'(c_q));
	assign d_src      = DAW'((dm1 * MS + 32'(t_q)) * MI + 32'(c_q));
	assign p_dst      = PAW'((32'(d_q) * MS + 32'(r_q)) * MS + 32'(c_q));
	assign d_dst      = DAW'((32'(d_q) * MS + 32'(r_q)) * MI + 32'(c_q));

	assign a_we    = cmd.exec_write && (mode_q == mpb_pkg::MODE_WRITE_A);
	assign b_we    = cmd.exec_write && (mode_q == mpb_pkg::MODE_WRITE_B);
	assign a_raddr = cmd.copy_step ? AAW'(cp_q) : a_mac_addr;
	assign b_raddr = BAW'(cp_q);
	assign p_raddr = cmd.read_issue ? s_addr : p_src;
	assign d_raddr = cmd.read_issue ? u_addr : d_src;

	// copy writes take priority; they never overlap a sum write-back
	assign p_we    = cpa_v_s1 || (last_s3 && !phase_d_q);
	assign p_waddr = cpa_v_s1 ? PAW'(cp_addr_s1) : p_dst;
	assign p_wdata = cpa_v_s1 ? (a_ok_s1 ? a_rdata : '0) : sat_val;
	assign d_we    = cpb_v_s1 || (last_s3 && phase_d_q);
	assign d_waddr = cpb_v_s1 ? DAW'(cp_addr_s1) : d_dst;
	assign d_wdata = cpb_v_s1 ? (b_ok_s1 ? b_rdata : '0) : sat_val;

	assign a_val   = a_ok_s1 ? signed'(a_rdata) : '0;
	assign src_val = phase_d_q ? signed'(d_rdata) : signed'(p_rdata);
	assign term    = prod_s2[2*DW-1:FW];

	always_comb begin
		if (acc_q > SAT_HI) begin
			sat_val = SAT_HI[DW-1:0];
			sat_hit = 1'b1;
		end else if (acc_q < SAT_LO) begin
			sat_val = SAT_LO[DW-1:0];
			sat_hit = 1'b1;
		end else begin
			sat_val = acc_q[DW-1:0];
			sat_hit = 1'b0;
		end
	end

	assign ram_val = (mode_q == mpb_pkg::MODE_READ_S) ? p_rdata : (u_zero ? '0 : d_rdata);
	assign out_free = !m_tvalid || m_tready;

	mpb_ram #(.WIDTH(DW), .DEPTH(PS_DEPTH)) u_a_ram (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(value_q),
		.raddr(a_raddr), .rdata(a_rdata)
	);
	mpb_ram #(.WIDTH(DW), .DEPTH(DS_DEPTH)) u_b_ram (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(value_q),
		.raddr(b_raddr), .rdata(b_rdata)
	);
	mpb_ram #(.WIDTH(DW), .DEPTH(PT_DEPTH)) u_power_ram (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);
	mpb_ram #(.WIDTH(DW), .DEPTH(DT_DEPTH)) u_drive_ram (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(d_raddr), .rdata(d_rdata)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mode_q  <= s_tuser;
			row_q   <= s_tdata[2:0];
			col_q   <= s_tdata[5:3];
			step_q  <= s_tdata[9:6];
			stage_q <= s_tdata[13:10];
			jin_q   <= s_tdata[15:14];
			value_q <= s_tdata[47:16];
		end
		if (cmd.res_set) begin
			res_st_q <= cmd.res_code;
			res_q    <= cmd.res_from_ram ? ram_val : '0;
		end
		if (cmd.out_load) begin
			m_tdata <= res_q;
			m_tuser <= res_st_q;
		end
		cp_addr_s1 <= cp_q;
		a_ok_s1    <= a_vld_q[a_raddr];
		b_ok_s1    <= b_vld_q[b_raddr];
		prod_s2    <= a_val * src_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_size_q   <= 4'd1;
			input_size_q   <= 3'd1;
			horizon_q      <= 5'd1;
			tables_valid_q <= 1'b0;
			sat_q          <= 1'b0;
			a_vld_q        <= '0;
			b_vld_q        <= '0;
			cp_q           <= '0;
			cpa_v_s1       <= 1'b0;
			cpb_v_s1       <= 1'b0;
			d_q            <= '0;
			r_q            <= '0;
			t_q            <= '0;
			c_q            <= '0;
			phase_d_q      <= 1'b0;
			v_s1           <= 1'b0;
			last_s1        <= 1'b0;
			v_s2           <= 1'b0;
			last_s2        <= 1'b0;
			last_s3        <= 1'b0;
			acc_q          <= '0;
			m_tvalid       <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mpb_pkg::CFG_STATE_SIZE: begin
						state_size_q   <= cfg_wdata[3:0];
						tables_valid_q <= 1'b0;
					end
					mpb_pkg::CFG_INPUT_SIZE: begin
						input_size_q   <= cfg_wdata[2:0];
						tables_valid_q <= 1'b0;
					end
					mpb_pkg::CFG_HORIZON: begin
						horizon_q      <= cfg_wdata;
						tables_valid_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (a_we) begin
				a_vld_q[a_waddr] <= 1'b1;
				tables_valid_q   <= 1'b0;
			end
			if (b_we) begin
				b_vld_q[b_waddr] <= 1'b1;
				tables_valid_q   <= 1'b0;
			end
			if (cmd.set_valid) begin
				tables_valid_q <= 1'b1;
			end
			if (cmd.clr_sat) begin
				sat_q <= 1'b0;
			end else if (last_s3 && sat_hit) begin
				sat_q <= 1'b1;
			end

			if (cmd.copy_start) begin
				cp_q <= '0;
			end else if (cmd.copy_step) begin
				cp_q <= cp_q + CPW'(1);
			end
			cpa_v_s1 <= cmd.copy_step && (32'(cp_q) < 32'(PS_DEPTH));
			cpb_v_s1 <= cmd.copy_step && (32'(cp_q) < 32'(DS_DEPTH));

			if (cmd.mac_start) begin
				d_q       <= HIW'(1);
				r_q       <= '0;
				c_q       <= '0;
				t_q       <= '0;
				phase_d_q <= 1'b0;
			end else if (cmd.mac_issue) begin
				t_q <= t_q + SIW'(1);
			end else if (cmd.elem_next) begin
				t_q <= '0;
				if (32'(c_q) == wl - 32'd1) begin
					c_q <= '0;
					if (32'(r_q) == 32'(n) - 32'd1) begin
						r_q <= '0;
						if (phase_d_q) begin
							phase_d_q <= 1'b0;
							d_q       <= d_q + HIW'(1);
						end else begin
							phase_d_q <= 1'b1;
						end
					end else begin
						r_q <= r_q + SIW'(1);
					end
				end else begin
					c_q <= c_q + CIW'(1);
				end
			end

			v_s1    <= cmd.mac_issue;
			last_s1 <= cmd.mac_issue && st.t_last;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			last_s3 <= v_s2 && last_s2;
			if (cmd.mac_start || last_s3) begin
				acc_q <= '0;
			end else if (v_s2) begin
				acc_q <= acc_q + ACC_W'(term);
			end

			if (cmd.out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_comb begin
		st.mode         = mode_q;
		st.bad          = bad;
		st.tables_valid = tables_valid_q;
		st.sat          = sat_q;
		st.nh_one       = (nh == HCW'(1));
		st.cp_last      = (cp_q == CPW'(CP_N - 1));
		st.t_last       = (32'(t_q) == 32'(n) - 32'd1);
		st.mac_busy     = v_s1 || v_s2 || last_s3;
		st.elem_last    = phase_d_q && (32'(d_q) == 32'(nh) - 32'd1)
		                  && (32'(r_q) == 32'(n) - 32'd1) && (32'(c_q) == 32'(m) - 32'd1);
		st.out_free     = out_free;
	end
endmodule
`default_nettype wire

### tb/mpc_prediction_matrix_builder_checker.sv
// Checker for the prediction matrix builder: predicts each result and compares it.
`timescale 1ns / 1ps
module mpc_prediction_matrix_builder_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [4:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [47:0] s_tdata,
	input  wire logic [2:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [31:0] m_tdata,
	input  wire logic [1:0]  m_tuser,
	output int               pending,
	output int               errors,
	output int               results_seen,
	output int               sat_seen
);
	localparam int NS = 8;
	localparam int NI = 4;
	localparam int NH = 16;

	typedef struct {
		logic [31:0] result;
		logic [1:0]  status;
	} entry_t;

	entry_t      expected_q[$];
	logic [31:0] a_mat[NS*NS];
	logic [31:0] b_mat[NS*NI];
	logic [31:0] powers[NH*NS*NS];
	logic [31:0] drives[NH*NS*NI];
	logic        valid_tables;
	logic        sat_flag;
	logic [3:0]  n_reg;
	logic [2:0]  m_reg;
	logic [4:0]  h_reg;
	int          err_cnt;

	function automatic int clamp(int v, int maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic logic [31:0] sat32(longint v);
		if (v > 64'sd2147483647) begin
			sat_flag = 1'b1;
			return 32'h7fffffff;
		end
		if (v < -64'sd2147483648) begin
			sat_flag = 1'b1;
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	// Truncating Q16.16 product: arithmetic shift floors toward minus infinity.
	function automatic longint qmul(logic [31:0] x, logic [31:0] y);
		longint p;
		p = longint'($signed(x)) * longint'($signed(y));
		return p >>> 16;
	endfunction

	function automatic void build_tables(int n, int m, int nh);
		longint acc;
		sat_flag = 1'b0;
		for (int k = 0; k < NS*NS; k++) powers[k] = a_mat[k];
		for (int k = 0; k < NS*NI; k++) drives[k] = b_mat[k];
		for (int d = 1; d < nh; d++) begin
			for (int r = 0; r < n; r++) begin
				for (int c = 0; c < n; c++) begin
					acc = 0;
					for (int t = 0; t < n; t++)
						acc += qmul(a_mat[r*NS+t], powers[(d-1)*NS*NS + t*NS + c]);
					powers[d*NS*NS + r*NS + c] = sat32(acc);
				end
				for (int c = 0; c < m; c++) begin
					acc = 0;
					for (int t = 0; t < n; t++)
						acc += qmul(a_mat[r*NS+t], drives[(d-1)*NS*NI + t*NI + c]);
					drives[d*NS*NI + r*NI + c] = sat32(acc);
				end
			end
		end
		valid_tables = 1'b1;
	endfunction

	function automatic entry_t predict_item(logic [2:0] mode, logic [47:0] d);
		entry_t e;
		int n, m, nh, row, col, stp, stg, j;
		n   = clamp(n_reg, NS);
		m   = clamp(m_reg, NI);
		nh  = clamp(h_reg, NH);
		row = d[2:0];
		col = d[5:3];
		stp = d[9:6];
		stg = d[13:10];
		j   = d[15:14];
		e.result = '0;
		e.status = mpb_pkg::STATUS_OK;
		case (mode)
			mpb_pkg::MODE_WRITE_A: begin
				if (row >= n || col >= n) e.status = mpb_pkg::STATUS_INDEX;
				else begin
					a_mat[row*NS+col] = d[47:16];
					valid_tables = 1'b0;
				end
			end
			mpb_pkg::MODE_WRITE_B: begin
				if (row >= n || col >= m) e.status = mpb_pkg::STATUS_INDEX;
				else begin
					b_mat[row*NI+col] = d[47:16];
					valid_tables = 1'b0;
				end
			end
			mpb_pkg::MODE_COMPUTE: begin
				build_tables(n, m, nh);
				e.status = sat_flag ? mpb_pkg::STATUS_SAT : mpb_pkg::STATUS_OK;
			end
			mpb_pkg::MODE_READ_S: begin
				if (stp >= nh || row >= n || col >= n) e.status = mpb_pkg::STATUS_INDEX;
				else if (!valid_tables) e.status = mpb_pkg::STATUS_NOTCOMP;
				else begin
					e.result = powers[stp*NS*NS + col*NS + row];
					e.status = sat_flag ? mpb_pkg::STATUS_SAT : mpb_pkg::STATUS_OK;
				end
			end
			mpb_pkg::MODE_READ_U: begin
				if (j >= m || stp >= nh || stg >= nh || row >= n)
					e.status = mpb_pkg::STATUS_INDEX;
				else if (!valid_tables) e.status = mpb_pkg::STATUS_NOTCOMP;
				else begin
					if (stg <= stp) e.result = drives[(stp-stg)*NS*NI + row*NI + j];
					e.status = sat_flag ? mpb_pkg::STATUS_SAT : mpb_pkg::STATUS_OK;
				end
			end
			default: e.status = mpb_pkg::STATUS_INDEX;
		endcase
		return e;
	endfunction

	task automatic report(string what, logic [31:0] want, logic [31:0] got);
		$display("%0t mismatch: %s expected %h got %h", $realtime, what, want, got);
		err_cnt++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		entry_t e;
		if (!arst_n) begin
			expected_q.delete();
			for (int k = 0; k < NS*NS; k++) a_mat[k] = '0;
			for (int k = 0; k < NS*NI; k++) b_mat[k] = '0;
			for (int k = 0; k < NH*NS*NS; k++) powers[k] = '0;
			for (int k = 0; k < NH*NS*NI; k++) drives[k] = '0;
			valid_tables = 1'b0;
			sat_flag     = 1'b0;
			n_reg = 4'd1;
			m_reg = 3'd1;
			h_reg = 5'd1;
			err_cnt = 0;
			pending <= 0;
			errors  <= 0;
			results_seen <= 0;
			sat_seen <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mpb_pkg::CFG_STATE_SIZE: begin
						n_reg = cfg_wdata[3:0];
						valid_tables = 1'b0;
					end
					mpb_pkg::CFG_INPUT_SIZE: begin
						m_reg = cfg_wdata[2:0];
						valid_tables = 1'b0;
					end
					mpb_pkg::CFG_HORIZON: begin
						h_reg = cfg_wdata;
						valid_tables = 1'b0;
					end
					default: ;
				endcase
			end
			// the oldest expectation belongs to the result, so pop before pushing
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) report("unexpected result", '0, m_tdata);
				else begin
					e = expected_q.pop_front();
					if (m_tdata !== e.result) report("result", e.result, m_tdata);
					if (m_tuser !== e.status) report("status", e.status, m_tuser);
					if (e.status == mpb_pkg::STATUS_SAT) sat_seen <= sat_seen + 1;
				end
				results_seen <= results_seen + 1;
			end
			if (s_tvalid && s_tready) expected_q.push_back(predict_item(s_tuser, s_tdata));
			pending <= expected_q.size();
			errors  <= err_cnt;
		end
	end

	final_check: assert property (@(posedge clk) 1) ;
endmodule

### tb/mpc_prediction_matrix_builder_top_test.sv
// Testbench top: drives stimulus into the prediction matrix builder and gives the verdict.
`timescale 1ns / 1ps
module mpc_prediction_matrix_builder_top_test;
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam logic [2:0] MODE_RSVD_LO  = 3'd5;
	localparam logic [2:0] MODE_RSVD_MID = 3'd6;
	localparam logic [2:0] MODE_RSVD_HI  = 3'd7;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_ITEMS = 1950;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [4:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	int          pending, errors, results_seen, sat_seen;
	int          cycles = 0;
	int          sent = 0;
	int          phases = 0;
	logic        quiet = 1'b0;
	int          n_cur, m_cur, h_cur;

	always #4 clk = ~clk;

	mpc_prediction_matrix_builder_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	mpc_prediction_matrix_builder_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.pending(pending), .errors(errors), .results_seen(results_seen), .sat_seen(sat_seen)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		m_tready <= quiet || ($urandom_range(99) >= 18);
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send(logic [2:0] mode, int row, int col, int stp, int stg, int j,
			logic [31:0] val);
		while (!quiet && $urandom_range(99) < 18) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {val, j[1:0], stg[3:0], stp[3:0], col[2:0], row[2:0]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_reg(logic [1:0] idx, int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[4:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Raw register values may be out of range; keep the clamped sizes for stimulus.
	task automatic configure(int n, int m, int h);
		wait_idle();
		set_reg(mpb_pkg::CFG_STATE_SIZE, n);
		set_reg(mpb_pkg::CFG_INPUT_SIZE, m);
		set_reg(mpb_pkg::CFG_HORIZON, h);
		n_cur = (n == 0) ? 1 : (n > 8 ? 8 : n);
		m_cur = (m == 0) ? 1 : (m > 4 ? 4 : m);
		h_cur = (h == 0) ? 1 : (h > 16 ? 16 : h);
	endtask

	function automatic logic [31:0] entry_value();
		int r;
		r = $urandom_range(99);
		if (r < 10) return $urandom;
		if (r < 20) return $urandom_range(0, 262144) - 131072;
		return $urandom_range(0, 52428) - 26214;
	endfunction

	task automatic noise_item();
		send($urandom_range(7), $urandom_range(7), $urandom_range(7), $urandom_range(15),
			$urandom_range(15), $urandom_range(3), $urandom);
	endtask

	// Load every entry, build the tables, then read them back with noise and recomputes mixed in.
	task automatic run_phase(int reads);
		for (int r = 0; r < n_cur; r++)
			for (int c = 0; c < n_cur; c++)
				send(mpb_pkg::MODE_WRITE_A, r, c, 0, 0, 0, entry_value());
		for (int r = 0; r < n_cur; r++)
			for (int c = 0; c < m_cur; c++)
				send(mpb_pkg::MODE_WRITE_B, r, c, 0, 0, 0, entry_value());
		send(mpb_pkg::MODE_COMPUTE, 0, 0, 0, 0, 0, $urandom);
		for (int k = 0; k < reads; k++) begin
			if ($urandom_range(99) < 8) noise_item();
			else if ($urandom_range(99) < 2)
				send(mpb_pkg::MODE_COMPUTE, 0, 0, 0, 0, 0, $urandom);
			else if ($urandom_range(1))
				send(mpb_pkg::MODE_READ_S, $urandom_range(n_cur-1), $urandom_range(n_cur-1),
					$urandom_range(h_cur-1), $urandom_range(15), $urandom_range(3), $urandom);
			else
				send(mpb_pkg::MODE_READ_U, $urandom_range(n_cur-1), $urandom_range(7),
					$urandom_range(h_cur-1), $urandom_range(h_cur-1),
					$urandom_range(m_cur-1), $urandom);
		end
		phases++;
	endtask

	initial begin
		int start;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		m_tready  <= 1'b0;
		n_cur = 1; m_cur = 1; h_cur = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: reads before compute, unknown modes, bad indices, extremes
		send(mpb_pkg::MODE_READ_S, 0, 0, 0, 0, 0, '0);
		send(mpb_pkg::MODE_READ_U, 0, 0, 0, 0, 0, '0);
		send(MODE_RSVD_LO, 7, 7, 15, 15, 3, 32'hffffffff);
		send(MODE_RSVD_MID, 0, 0, 0, 0, 0, '0);
		send(MODE_RSVD_HI, 0, 0, 0, 0, 0, '0);
		send(mpb_pkg::MODE_WRITE_A, 7, 7, 0, 0, 0, 32'h7fffffff);
		send(mpb_pkg::MODE_WRITE_B, 0, 7, 0, 0, 0, 32'h80000000);
		send(mpb_pkg::MODE_WRITE_A, 0, 0, 0, 0, 0, 32'h7fffffff);
		send(mpb_pkg::MODE_WRITE_B, 0, 0, 0, 0, 0, 32'h80000000);
		send(mpb_pkg::MODE_COMPUTE, 0, 0, 0, 0, 0, '0);
		send(mpb_pkg::MODE_READ_S, 0, 0, 0, 0, 0, '0);
		send(mpb_pkg::MODE_READ_U, 0, 0, 0, 0, 0, '0);
		send(mpb_pkg::MODE_READ_S, 0, 0, 1, 0, 0, '0);
		send(mpb_pkg::MODE_READ_U, 0, 0, 0, 1, 1, '0);
		wait_idle();
		set_reg(CFG_UNUSED, 31);
		send(mpb_pkg::MODE_READ_S, 0, 0, 0, 0, 0, '0);
		configure(2, 2, 3);
		send(mpb_pkg::MODE_WRITE_A, 0, 0, 0, 0, 0, 32'h00020000);
		send(mpb_pkg::MODE_WRITE_A, 1, 1, 0, 0, 0, 32'hfffe0000);
		send(mpb_pkg::MODE_WRITE_B, 1, 1, 0, 0, 0, 32'h00010000);
		send(mpb_pkg::MODE_COMPUTE, 0, 0, 0, 0, 0, '0);
		send(mpb_pkg::MODE_READ_U, 1, 0, 1, 2, 1, '0);
		send(mpb_pkg::MODE_READ_U, 1, 0, 2, 0, 1, '0);
		send(mpb_pkg::MODE_READ_S, 1, 1, 2, 0, 0, '0);

		start = sent;
		configure(15, 7, 31);
		run_phase(150);
		configure(0, 0, 0);
		run_phase(60);
		configure(8, 4, 16);
		run_phase(150);
		while (sent - start < RANDOM_ITEMS) begin
			configure($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 8));
			quiet = (phases == 5);
			run_phase($urandom_range(60, 160));
			quiet = 1'b0;
		end

		wait_idle();
		repeat (20) @(posedge clk);
		$display("run covered %0d transactions over %0d configurations", sent, phases);
		$display("%0d results checked, %0d reported saturation", results_seen, sat_seen);
		if (errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end
endmodule

### mpc_prediction_matrix_builder_top.f
+incdir+hw/rtl
hw/rtl/mpb_pkg.sv
hw/rtl/mpb_ram.sv
hw/rtl/mpb_ctrl.sv
hw/rtl/mpb_datapath.sv
hw/rtl/mpc_prediction_matrix_builder_top.sv
tb/mpc_prediction_matrix_builder_checker.sv
tb/mpc_prediction_matrix_builder_top_test.sv
